[hw/rtl/b64e_pkg.sv]
// shared types, constants and the character lookup for the base64 stream encoder
`timescale 1ns / 1ps

package b64e_pkg;

   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [7:0] PadChar = 8'h3D;

   // group phase, one-hot
   typedef enum logic [2:0] {
      PHASE_0 = 3'b001,
      PHASE_1 = 3'b010,
      PHASE_2 = 3'b100
   } phase_type;

   // work for the back end: up to four characters from one byte
   typedef struct packed {
      logic [3:0][5:0] sym;
      logic [3:0]      pad;
      logic [1:0]      num_m1;
      logic            last;
   } cmd_type;

   function automatic logic [7:0] sym_to_ascii(input logic [5:0] v);
      logic [7:0] ch;
      case (v) inside
         [6'd0 : 6'd25]:  ch = 8'h41 + {2'b00, v};
         [6'd26 : 6'd51]: ch = 8'h61 + {2'b00, v} - 8'd26;
         [6'd52 : 6'd61]: ch = 8'h30 + {2'b00, v} - 8'd52;
         6'd62:           ch = 8'h2B;
         6'd63:           ch = 8'h2F;
         default:         ch = 8'h2F;
      endcase
      return ch;
   endfunction

endpackage

[hw/rtl/b64e_front.sv]
// front end: tracks the group phase and splits each byte into character codes
`timescale 1ns / 1ps

module b64e_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   input  logic              q_full,
   output logic              q_push,
   output b64e_pkg::cmd_type q_cmd
);

   b64e_pkg::phase_type phase_ff, phase_in;
   logic [3:0] leftover_ff, leftover_in;

   assign q_push = req_push && !q_full;

   always_comb begin
      q_cmd        = '0;
      q_cmd.last   = req_last_byte;
      phase_in     = phase_ff;
      leftover_in  = leftover_ff;
      case (phase_ff)
         b64e_pkg::PHASE_1: begin
            q_cmd.sym[0] = {leftover_ff[1:0], req_data_byte[7:4]};
            leftover_in  = req_data_byte[3:0];
            phase_in     = b64e_pkg::PHASE_2;
            if (req_last_byte) begin
               q_cmd.sym[1] = {req_data_byte[3:0], 2'b00};
               q_cmd.pad[2] = 1'b1;
               q_cmd.num_m1 = 2'd2;
            end
         end
         b64e_pkg::PHASE_2: begin
            q_cmd.sym[0] = {leftover_ff, req_data_byte[7:6]};
            q_cmd.sym[1] = req_data_byte[5:0];
            q_cmd.num_m1 = 2'd1;
            leftover_in  = 4'd0;
            phase_in     = b64e_pkg::PHASE_0;
         end
         default: begin
            q_cmd.sym[0] = req_data_byte[7:2];
            leftover_in  = {2'b00, req_data_byte[1:0]};
            phase_in     = b64e_pkg::PHASE_1;
            if (req_last_byte) begin
               q_cmd.sym[1] = {req_data_byte[1:0], 4'b0000};
               q_cmd.pad[2] = 1'b1;
               q_cmd.pad[3] = 1'b1;
               q_cmd.num_m1 = 2'd3;
            end
         end
      endcase
      // end of message returns to the start of a group
      if (req_last_byte) begin
         phase_in    = b64e_pkg::PHASE_0;
         leftover_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= b64e_pkg::PHASE_0;
         leftover_ff <= 4'd0;
      end else if (q_push) begin
         phase_ff    <= phase_in;
         leftover_ff <= leftover_in;
      end
   end

endmodule

[hw/rtl/b64e_cmd_queue.sv]
// short queue of character work between the front and back ends
`timescale 1ns / 1ps

module b64e_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  b64e_pkg::cmd_type wr_cmd,
   output logic              full,
   input  logic              rd_en,
   output logic              not_empty,
   output b64e_pkg::cmd_type rd_cmd
);

   localparam int unsigned PtrW = b64e_pkg::QueuePtrWidth;
   localparam int unsigned CntW = b64e_pkg::QueueCountWidth;
   localparam logic [PtrW-1:0] LastPtr = PtrW'(b64e_pkg::QueueDepth - 1);

   b64e_pkg::cmd_type mem_ff [b64e_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(b64e_pkg::QueueDepth));
   assign not_empty = (count_ff != '0);
   assign rd_cmd    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CntW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

[hw/rtl/b64e_back.sv]
// back end: walks each entry, one character per cycle unless stalled
`timescale 1ns / 1ps

module b64e_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  b64e_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_last_char
);

   b64e_pkg::cmd_type cur_ff, cur_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       ovalid_ff, ovalid_in;
   logic [7:0] ochar_ff, ochar_in;
   logic       olast_ff, olast_in;
   logic       advance;
   logic       done;

   // output slot frees up when empty or taken this cycle
   assign advance = busy_ff && (!ovalid_ff || rsp_pop);
   assign done    = advance && (idx_ff == cur_ff.num_m1);
   assign q_pop   = q_not_empty && (!busy_ff || done);

   assign rsp_empty     = !ovalid_ff;
   assign rsp_out_char  = ochar_ff;
   assign rsp_last_char = olast_ff;

   always_comb begin
      cur_in    = cur_ff;
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      ovalid_in = ovalid_ff;
      ochar_in  = ochar_ff;
      olast_in  = olast_ff;
      if (q_pop) begin
         cur_in  = q_cmd;
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (advance) begin
         idx_in = idx_ff + 2'd1;
      end
      if (advance) begin
         ovalid_in = 1'b1;
         ochar_in  = cur_ff.pad[idx_ff] ? b64e_pkg::PadChar
                                         : b64e_pkg::sym_to_ascii(cur_ff.sym[idx_ff]);
         olast_in  = cur_ff.last && (idx_ff == cur_ff.num_m1);
      end else if (rsp_pop) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         idx_ff    <= 2'd0;
         ovalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         idx_ff    <= idx_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      ochar_ff <= ochar_in;
      olast_ff <= olast_in;
   end

   // index never runs past the entry's character count
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= cur_ff.num_m1))
      else $error("character index beyond entry length");

   // padding only ever fills the third and fourth characters
   a_pad_position: assert property (@(posedge clock) disable iff (reset)
      (advance && cur_ff.pad[idx_ff]) |-> (idx_ff == 2'd2 || idx_ff == 2'd3))
      else $error("padding emitted in a data position");

   // a loaded entry starts at its first character
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (busy_ff && idx_ff == 2'd0))
      else $error("entry load did not restart the index");

   // a result is produced only while an entry is in progress
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(ovalid_ff) && ovalid_ff) |-> $past(busy_ff))
      else $error("result appeared with no entry in progress");

endmodule

[hw/rtl/base64_stream_encoder_top.sv]
// top level of the streaming base64 encoder
`timescale 1ns / 1ps

// Base64 (standard alphabet, '=' padding) encoder for a byte stream.
// Input side is a queue: drive req_data_byte and req_last_byte with req_push;
// a transaction happens when req_push is high and req_full is low. Mark the
// final byte of each message with req_last_byte; any byte value is allowed.
// Output side is a queue: while rsp_empty is low, rsp_out_char holds the
// oldest character and rsp_last_char flags the end of the encoded message;
// raising rsp_pop takes it.
// Each byte yields one or two characters (up to four on the last byte, with
// padding). The front end turns a byte into character work in the cycle it
// is taken and writes it to a two-entry queue; the back end emits one
// character per cycle into the output register while the receiver takes
// them. A taken byte is held in the queue and then in the back end's entry
// register before its first character reaches the output register.
// Sustained rate is set by the single character output. When the receiver
// stalls, the output register holds, the back end waits, the queue fills
// and req_full rises; nothing is dropped. Synchronous reset empties the
// queue and output and returns to the start of a 3-byte group.
module base64_stream_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char
);

   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_not_empty;
   b64e_pkg::cmd_type q_wr_cmd;
   b64e_pkg::cmd_type q_rd_cmd;

   assign req_full = q_full;

   b64e_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_wr_cmd)
   );

   b64e_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (q_push),
      .wr_cmd    (q_wr_cmd),
      .full      (q_full),
      .rd_en     (q_pop),
      .not_empty (q_not_empty),
      .rd_cmd    (q_rd_cmd)
   );

   b64e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_cmd         (q_rd_cmd),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule
